[hw/rtl/bgg_pkg.sv]
// types, constants and register codes of the breathing glow gain block
package bgg_pkg;

   localparam int FRAC_BITS = 16;

   localparam int TIME_W    = 32;
   localparam int PHASE_W   = 24;
   localparam int GAIN_W    = 20;
   localparam int INT_W     = 18;
   localparam int REG_W     = 16;
   localparam int CSR_W     = 18;
   localparam int CSR_IDX_W = 3;
   localparam int GAIN_FRAC = 14;
   localparam int PHASE_FRAC = 16;
   localparam int PERIOD_FRAC = 8;

   // period in Q8.(8+F)
   localparam int PER_W = REG_W + FRAC_BITS;
   // time shifted up to the period scale, then F quotient bits
   localparam int DIV_STEPS = TIME_W + FRAC_BITS - PERIOD_FRAC + FRAC_BITS;
   localparam int SDIV_STEPS = FRAC_BITS;
   localparam int HASH_W = PHASE_W + FRAC_BITS + 3;

   localparam logic [FRAC_BITS+2:0] HASH1_MUL =
      (FRAC_BITS+3)'(((64'd273 << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic [FRAC_BITS-1:0] HASH1_ADD =
      FRAC_BITS'(((64'd17 << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic [FRAC_BITS+2:0] HASH2_MUL =
      (FRAC_BITS+3)'(((64'd417 << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic [FRAC_BITS-1:0] HASH2_ADD =
      FRAC_BITS'(((64'd31 << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic [FRAC_BITS-1:0] RISE_LO =
      FRAC_BITS'(((64'd32 << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic [FRAC_BITS-1:0] RISE_HI =
      FRAC_BITS'(((64'd44 << FRAC_BITS) + 64'd50) / 64'd100);
   localparam logic [FRAC_BITS-1:0] RISE_SPAN = RISE_HI - RISE_LO;

   localparam logic [FRAC_BITS:0]   ONE_F   = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [FRAC_BITS+1:0] THREE_F = {2'b11, {FRAC_BITS{1'b0}}};

   localparam logic [INT_W-1:0]  INT_CAP  = INT_W'(196608);
   localparam logic [GAIN_W-1:0] GAIN_CAP = GAIN_W'(786432);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GLOW_ENABLE      = 3'd0,
      CSR_BREATHING_ENABLE = 3'd1,
      CSR_GLOW_INTENSITY   = 3'd2,
      CSR_PERIOD_MIN       = 3'd3,
      CSR_PERIOD_MAX       = 3'd4,
      CSR_GAIN_MIN         = 3'd5,
      CSR_GAIN_MAX         = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [PER_W-1:0]     period;
      logic [PER_W-1:0]     rem;
      logic [FRAC_BITS-1:0] quo;
      logic [TIME_W-1:0]    t;
      logic [FRAC_BITS-1:0] rise;
      logic [FRAC_BITS-1:0] phf;
   } div_stage_type;

   typedef struct packed {
      logic [FRAC_BITS-1:0] rem;
      logic [FRAC_BITS-1:0] d;
      logic [FRAC_BITS-1:0] quo;
      logic                 up;
   } sdiv_stage_type;

endpackage

[hw/rtl/breathing_glow_gain.sv]
// breathing glow gain: per-item gain from time and phase, fully pipelined
// the cycle position and the smoothstep argument come from restoring dividers
// that resolve one quotient bit per stage
// throughput: one item per cycle; a stalled result freezes the whole pipeline
// reset: synchronous, clears all valid bits and loads the register defaults
module breathing_glow_gain import bgg_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [TIME_W-1:0]    req_time_seconds,
   input  logic [PHASE_W-1:0]   req_phase_offset,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [GAIN_W-1:0]    rsp_gain,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int F = FRAC_BITS;

   function automatic div_stage_type div_step(div_stage_type src);
      logic [PER_W:0] trial;
      logic           take;
      div_stage_type  res;
      trial = {src.rem, src.t[TIME_W-1]};
      take  = trial >= {1'b0, src.period};
      res   = src;
      res.rem = take ? PER_W'(trial - {1'b0, src.period}) : trial[PER_W-1:0];
      res.quo = {src.quo[F-2:0], take};
      res.t   = {src.t[TIME_W-2:0], 1'b0};
      return res;
   endfunction

   function automatic sdiv_stage_type sdiv_step(sdiv_stage_type src);
      logic [F:0]     trial;
      logic           take;
      sdiv_stage_type res;
      trial = {src.rem, 1'b0};
      take  = trial >= {1'b0, src.d};
      res   = src;
      res.rem = take ? F'(trial - {1'b0, src.d}) : trial[F-1:0];
      res.quo = {src.quo[F-2:0], take};
      return res;
   endfunction

   // configuration
   logic              glow_en_ff;
   logic              breath_en_ff;
   logic [INT_W-1:0]  intensity_ff;
   logic [REG_W-1:0]  period_min_ff;
   logic [REG_W-1:0]  period_max_ff;
   logic [REG_W-1:0]  gain_min_ff;
   logic [REG_W-1:0]  gain_max_ff;
   logic [INT_W-1:0]  intensity_in;

   assign intensity_in = (csr_wdata[INT_W-1:0] > INT_CAP) ? INT_CAP : csr_wdata[INT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         glow_en_ff    <= 1'b0;
         breath_en_ff  <= 1'b0;
         intensity_ff  <= INT_W'(65536);
         period_min_ff <= REG_W'(768);
         period_max_ff <= REG_W'(1536);
         gain_min_ff   <= REG_W'(8192);
         gain_max_ff   <= REG_W'(16384);
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_GLOW_ENABLE:      glow_en_ff    <= csr_wdata[0];
            CSR_BREATHING_ENABLE: breath_en_ff  <= csr_wdata[0];
            CSR_GLOW_INTENSITY:   intensity_ff  <= intensity_in;
            CSR_PERIOD_MIN:       period_min_ff <= csr_wdata[REG_W-1:0];
            CSR_PERIOD_MAX:       period_max_ff <= csr_wdata[REG_W-1:0];
            CSR_GAIN_MIN:         gain_min_ff   <= csr_wdata[REG_W-1:0];
            CSR_GAIN_MAX:         gain_max_ff   <= csr_wdata[REG_W-1:0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic rsp_valid_ff;
   logic [GAIN_W-1:0] rsp_gain_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_gain  = rsp_gain_ff;

   // stage 1: phase hashes
   logic [HASH_W-1:0]   hprod1;
   logic [HASH_W-1:0]   hprod2;
   logic [F+15:0]       phx;
   logic [F-1:0]        h1_in, ch_in, phf1_in;
   logic                s1_vld_ff;
   logic [TIME_W-1:0]   t1_ff;
   logic [F-1:0]        h1_ff, ch1_ff, phf1_ff;

   assign hprod1  = HASH_W'(req_phase_offset) * HASH_W'(HASH1_MUL);
   assign hprod2  = HASH_W'(req_phase_offset) * HASH_W'(HASH2_MUL);
   assign h1_in   = hprod1[PHASE_FRAC+F-1:PHASE_FRAC] + HASH1_ADD;
   assign ch_in   = hprod2[PHASE_FRAC+F-1:PHASE_FRAC] + HASH2_ADD;
   assign phx     = (F+16)'(req_phase_offset[PHASE_FRAC-1:0]) << F;
   assign phf1_in = phx[F+15:16];

   // stage 2: period and rise point
   logic signed [REG_W:0]   pdiff;
   logic signed [PER_W+1:0] pprod;
   logic signed [PER_W+1:0] pe;
   logic [PER_W-1:0]        period_in;
   logic [2*F-1:0]          rprod;
   logic [F-1:0]            rise_in;
   logic                    s2_vld_ff;
   logic [PER_W-1:0]        period2_ff;
   logic [TIME_W-1:0]       t2_ff;
   logic [F-1:0]            rise2_ff, phf2_ff;

   assign pdiff = $signed({1'b0, period_max_ff}) - $signed({1'b0, period_min_ff});
   assign pprod = (PER_W+2)'(pdiff) * $signed((PER_W+2)'({1'b0, h1_ff}));
   assign pe    = $signed({2'b00, period_min_ff, {F{1'b0}}}) + pprod;
   assign period_in = (pe > 0) ? pe[PER_W-1:0] : PER_W'(1);
   assign rprod   = (2*F)'(RISE_SPAN) * (2*F)'(ch1_ff);
   assign rise_in = RISE_LO + rprod[2*F-1:F];

   // divider chain: time / period, fractional quotient bits
   div_stage_type           div_src;
   div_stage_type           div_in [DIV_STEPS];
   div_stage_type           div_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0]    div_vld_ff;

   always_comb begin
      div_src.period = period2_ff;
      div_src.rem    = '0;
      div_src.quo    = '0;
      div_src.t      = t2_ff;
      div_src.rise   = rise2_ff;
      div_src.phf    = phf2_ff;
      div_in[0] = div_step(div_src);
      for (int k = 1; k < DIV_STEPS; k++) begin
         div_in[k] = div_step(div_ff[k-1]);
      end
   end

   // stage 3: cycle position
   logic [F-1:0] cycle_in;
   logic         s3_vld_ff;
   logic [F-1:0] cycle3_ff, rise3_ff;

   assign cycle_in = div_ff[DIV_STEPS-1].quo + div_ff[DIV_STEPS-1].phf;

   // stage 4: pick the rising or falling edge, only one needs a division
   logic                 up_in;
   logic [F:0]           fall_w;
   sdiv_stage_type       sdiv_src_in;
   logic                 s4_vld_ff;
   sdiv_stage_type       s4_ff;

   assign up_in  = cycle3_ff < rise3_ff;
   assign fall_w = ONE_F - {1'b0, rise3_ff};

   always_comb begin
      sdiv_src_in.quo = '0;
      sdiv_src_in.up  = up_in;
      if (up_in) begin
         sdiv_src_in.rem = cycle3_ff;
         sdiv_src_in.d   = rise3_ff;
      end else begin
         sdiv_src_in.rem = cycle3_ff - rise3_ff;
         sdiv_src_in.d   = fall_w[F-1:0];
      end
   end

   sdiv_stage_type        sdiv_in [SDIV_STEPS];
   sdiv_stage_type        sdiv_ff [SDIV_STEPS];
   logic [SDIV_STEPS-1:0] sdiv_vld_ff;

   always_comb begin
      sdiv_in[0] = sdiv_step(s4_ff);
      for (int k = 1; k < SDIV_STEPS; k++) begin
         sdiv_in[k] = sdiv_step(sdiv_ff[k-1]);
      end
   end

   // stage 5: x squared and 3 - 2x
   logic [F-1:0]   xq;
   logic [2*F-1:0] sq;
   logic [F-1:0]   x2_in;
   logic [F+1:0]   t3_in;
   logic           s5_vld_ff;
   logic [F-1:0]   x2_ff;
   logic [F+1:0]   t3_ff;
   logic           up5_ff;

   assign xq    = sdiv_ff[SDIV_STEPS-1].quo;
   assign sq    = (2*F)'(xq) * (2*F)'(xq);
   assign x2_in = sq[2*F-1:F];
   assign t3_in = THREE_F - {1'b0, xq, 1'b0};

   // stage 6: smoothstep and breath value
   logic [2*F+1:0] sprod;
   logic [F:0]     smooth_w;
   logic [F:0]     breath_in;
   logic           s6_vld_ff;
   logic [F:0]     breath_ff;

   assign sprod     = (2*F+2)'(x2_ff) * (2*F+2)'(t3_ff);
   assign smooth_w  = sprod[2*F:F];
   assign breath_in = up5_ff ? smooth_w : ONE_F - smooth_w;

   // stage 7: interpolate between gain_min and gain_max
   logic signed [REG_W:0]       gdiff;
   logic signed [REG_W+F+2:0]   gprod;
   logic signed [REG_W+F+2:0]   gsum;
   logic [REG_W+F-1:0]          ge_in;
   logic                        s7_vld_ff;
   logic [REG_W+F-1:0]          ge_ff;

   assign gdiff = $signed({1'b0, gain_max_ff}) - $signed({1'b0, gain_min_ff});
   assign gprod = (REG_W+F+3)'(gdiff) * $signed((REG_W+F+3)'({1'b0, breath_ff}));
   assign gsum  = $signed({3'b000, gain_min_ff, {F{1'b0}}}) + gprod;
   assign ge_in = (gsum < 0) ? '0 : gsum[REG_W+F-1:0];

   // output stage: scale by intensity, saturate, bypass modes
   logic [REG_W+F+INT_W-1:0]       gmul;
   logic [REG_W+INT_W-GAIN_FRAC-1:0] gshift;
   logic [GAIN_W-1:0]              gain_calc;
   logic [GAIN_W-1:0]              rsp_gain_in;

   assign gmul   = (REG_W+F+INT_W)'(ge_ff) * (REG_W+F+INT_W)'(intensity_ff);
   assign gshift = gmul[REG_W+F+INT_W-1:GAIN_FRAC+F];
   assign gain_calc = (gshift > (REG_W+INT_W-GAIN_FRAC)'(GAIN_CAP)) ? GAIN_CAP
                                                                    : GAIN_W'(gshift);

   always_comb begin
      if (!glow_en_ff || intensity_ff == '0) begin
         rsp_gain_in = '0;
      end else if (!breath_en_ff) begin
         rsp_gain_in = GAIN_W'(intensity_ff);
      end else begin
         rsp_gain_in = gain_calc;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         div_vld_ff   <= '0;
         s3_vld_ff    <= 1'b0;
         s4_vld_ff    <= 1'b0;
         sdiv_vld_ff  <= '0;
         s5_vld_ff    <= 1'b0;
         s6_vld_ff    <= 1'b0;
         s7_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff    <= req_valid;
         s2_vld_ff    <= s1_vld_ff;
         div_vld_ff   <= {div_vld_ff[DIV_STEPS-2:0], s2_vld_ff};
         s3_vld_ff    <= div_vld_ff[DIV_STEPS-1];
         s4_vld_ff    <= s3_vld_ff;
         sdiv_vld_ff  <= {sdiv_vld_ff[SDIV_STEPS-2:0], s4_vld_ff};
         s5_vld_ff    <= sdiv_vld_ff[SDIV_STEPS-1];
         s6_vld_ff    <= s5_vld_ff;
         s7_vld_ff    <= s6_vld_ff;
         rsp_valid_ff <= s7_vld_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         t1_ff      <= req_time_seconds;
         h1_ff      <= h1_in;
         ch1_ff     <= ch_in;
         phf1_ff    <= phf1_in;
         period2_ff <= period_in;
         t2_ff      <= t1_ff;
         rise2_ff   <= rise_in;
         phf2_ff    <= phf1_ff;
         div_ff     <= div_in;
         cycle3_ff  <= cycle_in;
         rise3_ff   <= div_ff[DIV_STEPS-1].rise;
         s4_ff      <= sdiv_src_in;
         sdiv_ff    <= sdiv_in;
         x2_ff      <= x2_in;
         t3_ff      <= t3_in;
         up5_ff     <= sdiv_ff[SDIV_STEPS-1].up;
         breath_ff  <= breath_in;
         ge_ff      <= ge_in;
         rsp_gain_ff <= rsp_gain_in;
      end
   end

endmodule

[test/tb.sv]
// testbench for the breathing glow gain block: directed and random items against a predictor
module tb import bgg_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [TIME_W-1:0]    req_time_seconds = '0;
   logic [PHASE_W-1:0]   req_phase_offset = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [GAIN_W-1:0]    rsp_gain;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   breathing_glow_gain i_dut (.*);

   always #5 clock = ~clock;

   // shadow copy of the registers
   longint unsigned glow_on, breath_on, intensity, per_lo, per_hi, g_lo, g_hi;

   logic [GAIN_W-1:0] expected_gains[$];
   int  mismatches = 0;
   bit  send_quiet = 1'b0;
   bit  rsp_quiet = 1'b0;

   function automatic longint unsigned hundredths(longint unsigned n);
      return ((n << 16) + 50) / 100;
   endfunction

   function automatic longint unsigned smoothstep_q(longint unsigned x);
      longint unsigned x2;
      x2 = (x * x) >> 16;
      return (x2 * (3 * 65536 - 2 * x)) >> 16;
   endfunction

   function automatic logic [GAIN_W-1:0] predict_gain(longint unsigned t, longint unsigned ph);
      longint unsigned h1, ch, period, rem, qf, cycle, rise, xu, xd, up, down, breath, g;
      longint pe, ge;
      if (glow_on == 0 || intensity == 0) begin
         g = 0;
      end else if (breath_on == 0) begin
         g = intensity;
      end else begin
         h1 = (((ph * hundredths(273)) >> 16) + hundredths(17)) & 64'hFFFF;
         pe = longint'(per_lo << 16) + (longint'(per_hi) - longint'(per_lo)) * longint'(h1);
         period = pe > 0 ? longint'(pe) : 1;
         rem = (t << 8) % period;
         qf = (rem << 16) / period;
         cycle = (qf + (ph & 64'hFFFF)) & 64'hFFFF;
         ch = (((ph * hundredths(417)) >> 16) + hundredths(31)) & 64'hFFFF;
         rise = hundredths(32) + (((hundredths(44) - hundredths(32)) * ch) >> 16);
         xu = (cycle << 16) / rise;
         if (xu > 65536) xu = 65536;
         if (cycle <= rise) begin
            xd = 0;
         end else begin
            xd = ((cycle - rise) << 16) / (65536 - rise);
            if (xd > 65536) xd = 65536;
         end
         up = smoothstep_q(xu);
         down = smoothstep_q(xd);
         if (down > 65536) down = 65536;
         breath = (up * (65536 - down)) >> 16;
         ge = longint'(g_lo << 16) + (longint'(g_hi) - longint'(g_lo)) * longint'(breath);
         if (ge < 0) ge = 0;
         g = (longint'(ge) * intensity) >> 30;
      end
      if (g > 786432) g = 786432;
      return g[GAIN_W-1:0];
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_GLOW_ENABLE:      glow_on = data[0];
         CSR_BREATHING_ENABLE: breath_on = data[0];
         CSR_GLOW_INTENSITY:   intensity = data > 196608 ? 196608 : data;
         CSR_PERIOD_MIN:       per_lo = data[15:0];
         CSR_PERIOD_MAX:       per_hi = data[15:0];
         CSR_GAIN_MIN:         g_lo = data[15:0];
         CSR_GAIN_MAX:         g_hi = data[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // wait until every expected gain is back, then let the pipeline drain
   task automatic drain;
      while (expected_gains.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic send_item(input logic [TIME_W-1:0] t, input logic [PHASE_W-1:0] ph);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_time_seconds <= t;
      req_phase_offset <= ph;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      expected_gains = {expected_gains, predict_gain(t, ph)};
      @(negedge clock);
   endtask

   task automatic end_burst;
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h0001;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_defaults;
      // glow is off after reset
      send_item(32'h0, 24'h0);
      send_item(32'hFFFF_FFFF, 24'hFF_FFFF);
      end_burst();
      drain();
   endtask

   task automatic test_static_gain;
      write_reg(CSR_GLOW_ENABLE, 18'd1);
      send_item(32'h1234_5678, 24'h12_3456);
      end_burst();
      drain();
      write_reg(CSR_IDX_W'(7), 18'h3FFFF);  // unknown index, ignored
      write_reg(CSR_GLOW_INTENSITY, 18'h3FFFF);  // clamps to 3.0
      send_item(32'h0, 24'h0);
      end_burst();
      drain();
      write_reg(CSR_GLOW_INTENSITY, 18'd0);
      send_item(32'hFFFF_FFFF, 24'hFF_FFFF);
      end_burst();
      drain();
   endtask

   task automatic test_breathing_directed;
      write_reg(CSR_GLOW_INTENSITY, 18'd196608);
      write_reg(CSR_BREATHING_ENABLE, 18'd1);
      send_item(32'h0, 24'h0);
      send_item(32'hFFFF_FFFF, 24'hFF_FFFF);
      send_item(32'h0002_8000, 24'h00_4000);
      send_item(32'h8000_0000, 24'h80_0000);
      end_burst();
      drain();
      // zero period falls back to the smallest one
      write_reg(CSR_PERIOD_MIN, 18'd0);
      write_reg(CSR_PERIOD_MAX, 18'd0);
      write_reg(CSR_GAIN_MIN, 18'hFFFF);
      write_reg(CSR_GAIN_MAX, 18'hFFFF);
      send_item(32'h0001_0000, 24'h00_1234);
      send_item(32'hFFFF_FFFF, 24'hFF_FFFF);
      end_burst();
      drain();
      // max period below min, gain going down
      write_reg(CSR_PERIOD_MIN, 18'hFFFF);
      write_reg(CSR_PERIOD_MAX, 18'd1);
      write_reg(CSR_GAIN_MIN, 18'hFFFF);
      write_reg(CSR_GAIN_MAX, 18'd0);
      for (int i = 0; i < 8; i++) send_item(32'($urandom), 24'($urandom));
      end_burst();
      drain();
   endtask

   task automatic test_random;
      for (int p = 0; p < 10; p++) begin
         write_reg(CSR_GLOW_ENABLE, 18'($urandom_range(0, 7) != 0));
         write_reg(CSR_BREATHING_ENABLE, 18'($urandom_range(0, 7) != 0));
         write_reg(CSR_GLOW_INTENSITY, $urandom_range(0, 3) == 0 ? 18'h3FFFF : 18'($urandom));
         write_reg(CSR_PERIOD_MIN, 18'(pick16()));
         write_reg(CSR_PERIOD_MAX, 18'(pick16()));
         write_reg(CSR_GAIN_MIN, 18'(pick16()));
         write_reg(CSR_GAIN_MAX, 18'(pick16()));
         send_quiet = $urandom_range(0, 3) == 0;
         rsp_quiet = $urandom_range(0, 3) == 0;
         for (int i = 0; i < 153; i++) begin
            if ($urandom_range(0, 3) == 0)
               send_item(32'($urandom_range(0, 32'h000F_FFFF)), 24'($urandom));
            else
               send_item(32'($urandom), 24'($urandom));
         end
         end_burst();
         drain();
      end
   endtask

   // result side back-pressure
   initial begin
      int n;
      forever begin
         @(negedge clock);
         n = rsp_quiet ? 0 : $urandom_range(0, 7);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         forever begin
            @(posedge clock);
            if (rsp_valid && !rsp_stall) break;
         end
      end
   end

   always @(posedge clock) begin
      logic [GAIN_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_gains.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item: gain %0d", rsp_gain);
         end else begin
            want = expected_gains.pop_front();
            if (rsp_gain !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("gain mismatch: expected %0d actual %0d", want, rsp_gain);
            end
         end
      end
   end

   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      glow_on = 0; breath_on = 0; intensity = 65536;
      per_lo = 768; per_hi = 1536; g_lo = 8192; g_hi = 16384;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_defaults();
      test_static_gain();
      test_breathing_directed();
      test_random();
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
